// ===== rtl/twt_pkg.sv =====
// Shared types, character codes and letter folding for the transcript word tokenizer.
package twt_pkg;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_RND_OP = 8'h28;
    localparam logic [7:0] CH_RND_CL = 8'h29;
    localparam logic [7:0] CH_SQ_OP  = 8'h5B;
    localparam logic [7:0] CH_SQ_CL  = 8'h5D;
    localparam logic [7:0] CH_NEL    = 8'h85;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;
    localparam logic [7:0] CH_A_GRV  = 8'hE0;
    localparam logic [7:0] CH_A_TIL  = 8'hE3;
    localparam logic [7:0] CH_E_GRV  = 8'hE8;
    localparam logic [7:0] CH_E_CIR  = 8'hEA;
    localparam logic [7:0] CH_O_GRV  = 8'hD2;
    localparam logic [7:0] CH_O_ACU  = 8'hD3;
    localparam logic [7:0] CH_U_GRV  = 8'hF9;
    localparam logic [7:0] CH_U_CIR  = 8'hFB;
    localparam logic [6:0] LTR_NONE  = 7'd0;
    localparam logic [6:0] LTR_A     = 7'h41;
    localparam logic [6:0] LTR_E     = 7'h45;
    localparam logic [6:0] LTR_O     = 7'h4F;
    localparam logic [6:0] LTR_U     = 7'h55;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam logic [15:0] LINE_ONE = 16'd1;

    typedef enum logic [1:0] {
        MODE_SPACE,
        MODE_WORD,
        MODE_PUNCT,
        MODE_TAG
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_SQUARE,
        ERR_ROUND,
        ERR_NEST
    } err_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  square_depth;
        logic [1:0]  round_depth;
        logic [15:0] line_count;
        err_t        error_latch;
        logic        orig_started;
    } state_t;

    typedef struct packed {
        logic        pair_end;
        logic        word_valid;
        logic [6:0]  word_char;
        logic        orig_valid;
        logic [7:0]  orig_char;
        err_t        error_code;
        logic [15:0] line_number;
    } result_t;

    function automatic logic [6:0] fold_letter(input logic [7:0] c);
        logic [6:0] r;
        r = LTR_NONE;
        if (c >= CH_LO_A && c <= CH_LO_Z)
            r = 7'(c - CASE_DIFF);
        else if (c >= CH_UP_A && c <= CH_UP_Z)
            r = c[6:0];
        else if (c >= CH_E_GRV && c <= CH_E_CIR)
            r = LTR_E;
        else if (c == CH_O_GRV || c == CH_O_ACU)
            r = LTR_O;
        else if (c >= CH_A_GRV && c <= CH_A_TIL)
            r = LTR_A;
        else if (c >= CH_U_GRV && c <= CH_U_CIR)
            r = LTR_U;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_NEL;
    endfunction

endpackage

// ===== rtl/twt_in_if.sv =====
// Byte input channel: valid/ready with one text byte.
interface twt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// ===== rtl/twt_out_if.sv =====
// Token output channel: valid/ready with one tokenizer result.
interface twt_out_if;
    logic        valid;
    logic        ready;
    logic        pair_end;
    logic        word_valid;
    logic [6:0]  word_char;
    logic        orig_valid;
    logic [7:0]  orig_char;
    logic [1:0]  error_code;
    logic [15:0] line_number;

    modport source (output valid, output pair_end, output word_valid, output word_char,
                    output orig_valid, output orig_char, output error_code,
                    output line_number, input ready);
    modport sink   (input valid, input pair_end, input word_valid, input word_char,
                    input orig_valid, input orig_char, input error_code,
                    input line_number, output ready);
endinterface

// ===== rtl/twt_step.sv =====
// Per-byte decision logic: next tokenizer state and the result for one byte.
module twt_step (
    input  twt_pkg::state_t  state,
    input  logic [7:0]       char_in,
    output twt_pkg::state_t  state_next,
    output twt_pkg::result_t result
);

    logic [6:0]    letter;
    logic [7:0]    shown;
    logic          tag_open;
    logic          tag_close;
    logic          pend;
    logic          wv;
    logic          ov;
    twt_pkg::err_t err;

    assign letter    = twt_pkg::fold_letter(char_in);
    assign shown     = (char_in == twt_pkg::CH_LF) ? twt_pkg::CH_SPACE : char_in;
    assign tag_open  = (char_in == twt_pkg::CH_SQ_OP) || (char_in == twt_pkg::CH_RND_OP);
    assign tag_close = (char_in == twt_pkg::CH_SQ_CL) || (char_in == twt_pkg::CH_RND_CL);

    always_comb
    begin
        state_next = state;
        pend       = 1'b0;
        wv         = 1'b0;
        ov         = 1'b0;
        err        = twt_pkg::ERR_NONE;

        if (state.error_latch == twt_pkg::ERR_NONE && char_in != twt_pkg::CH_CR)
        begin
            if (char_in == twt_pkg::CH_LF && state.line_count != twt_pkg::LINE_MAX)
                state_next.line_count = state.line_count + twt_pkg::LINE_ONE;

            priority if (char_in == twt_pkg::CH_SQ_OP)
            begin
                if (state.square_depth != 2'd0)
                    err = twt_pkg::ERR_SQUARE;
                else if (state.round_depth != 2'd0)
                    err = twt_pkg::ERR_NEST;
            end
            else if (char_in == twt_pkg::CH_SQ_CL)
            begin
                if (state.square_depth == 2'd0)
                    err = twt_pkg::ERR_SQUARE;
            end
            else if (char_in == twt_pkg::CH_RND_OP)
            begin
                if (state.round_depth != 2'd0)
                    err = twt_pkg::ERR_ROUND;
                else if (state.square_depth != 2'd0)
                    err = twt_pkg::ERR_NEST;
            end
            else if (char_in == twt_pkg::CH_RND_CL)
            begin
                if (state.round_depth == 2'd0)
                    err = twt_pkg::ERR_ROUND;
            end
            else
            begin
                err = twt_pkg::ERR_NONE;
            end

            if (err != twt_pkg::ERR_NONE)
            begin
                state_next.error_latch = err;
            end
            else
            begin
                if (char_in == twt_pkg::CH_SQ_OP)  state_next.square_depth = 2'd1;
                if (char_in == twt_pkg::CH_SQ_CL)  state_next.square_depth = 2'd0;
                if (char_in == twt_pkg::CH_RND_OP) state_next.round_depth  = 2'd1;
                if (char_in == twt_pkg::CH_RND_CL) state_next.round_depth  = 2'd0;

                unique case (state.mode)
                    twt_pkg::MODE_SPACE:
                    begin
                        ov = 1'b1;
                        if (tag_open)
                            state_next.mode = twt_pkg::MODE_TAG;
                        else if (letter != twt_pkg::LTR_NONE)
                        begin
                            wv = 1'b1;
                            state_next.mode = twt_pkg::MODE_WORD;
                        end
                    end
                    twt_pkg::MODE_WORD:
                    begin
                        if (tag_open)
                        begin
                            pend = 1'b1;
                            ov   = 1'b1;
                            state_next.mode = twt_pkg::MODE_TAG;
                        end
                        else if (letter != twt_pkg::LTR_NONE)
                        begin
                            wv = 1'b1;
                            ov = 1'b1;
                        end
                        else if (char_in == twt_pkg::CH_APOS)
                            ov = 1'b1;
                        else if (twt_pkg::is_space(char_in))
                        begin
                            pend = 1'b1;
                            state_next.mode = twt_pkg::MODE_SPACE;
                        end
                        else
                        begin
                            ov = 1'b1;
                            state_next.mode = twt_pkg::MODE_PUNCT;
                        end
                    end
                    twt_pkg::MODE_PUNCT:
                    begin
                        if (tag_open)
                        begin
                            pend = 1'b1;
                            ov   = 1'b1;
                            state_next.mode = twt_pkg::MODE_TAG;
                        end
                        else if (letter != twt_pkg::LTR_NONE)
                        begin
                            pend = 1'b1;
                            wv   = 1'b1;
                            ov   = 1'b1;
                            state_next.mode = twt_pkg::MODE_WORD;
                        end
                        else if (twt_pkg::is_space(char_in))
                        begin
                            pend = 1'b1;
                            state_next.mode = twt_pkg::MODE_SPACE;
                        end
                        else
                            ov = 1'b1;
                    end
                    twt_pkg::MODE_TAG:
                    begin
                        ov = 1'b1;
                        if (tag_close)
                            state_next.mode = twt_pkg::MODE_SPACE;
                    end
                endcase

                // drop leading spaces of a fresh pair
                if (ov && !(state.orig_started && !pend) && shown == twt_pkg::CH_SPACE)
                    ov = 1'b0;
                if (pend)
                    state_next.orig_started = 1'b0;
                if (ov)
                    state_next.orig_started = 1'b1;
            end
        end

        result.pair_end    = pend;
        result.word_valid  = wv;
        result.word_char   = wv ? letter : twt_pkg::LTR_NONE;
        result.orig_valid  = ov;
        result.orig_char   = ov ? shown : 8'd0;
        result.error_code  = state_next.error_latch;
        result.line_number = state_next.line_count;
    end

endmodule

// ===== rtl/twt_out_reg.sv =====
// Result register with valid flag between the decision logic and the output channel.
module twt_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  twt_pkg::result_t load_data,
    output logic             can_load,
    twt_out_if.source        tok_ch
);

    logic             valid_reg;
    logic             valid_next;
    twt_pkg::result_t data_reg;

    assign can_load   = !valid_reg || tok_ch.ready;
    assign valid_next = load || (valid_reg && !tok_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign tok_ch.valid       = valid_reg;
    assign tok_ch.pair_end    = data_reg.pair_end;
    assign tok_ch.word_valid  = data_reg.word_valid;
    assign tok_ch.word_char   = data_reg.word_char;
    assign tok_ch.orig_valid  = data_reg.orig_valid;
    assign tok_ch.orig_char   = data_reg.orig_char;
    assign tok_ch.error_code  = data_reg.error_code;
    assign tok_ch.line_number = data_reg.line_number;

endmodule

// ===== rtl/transcript_word_tokenizer_core.sv =====
// Top level of the transcript word tokenizer: state registers, decision logic, result register.
//
// Takes one Latin-1 byte per transfer and returns exactly one result per byte, in order.
// Throughput is one byte per cycle; a result is offered the cycle after its byte transfers,
// and a new byte is taken whenever the result register is empty or being emptied.
// The figure is set by the loop through the mode, bracket depth, line count, orig_started
// and error registers. After a bracket error every later byte yields a result with all
// flags low, carrying the latched error code and the frozen line count.
module transcript_word_tokenizer_core (
    input  logic      clk,
    input  logic      rst_n,
    twt_in_if.sink    char_ch,
    twt_out_if.source tok_ch
);

    twt_pkg::state_t  state_reg;
    twt_pkg::state_t  state_next;
    twt_pkg::result_t step_result;
    logic             can_load;
    logic             accept;

    assign char_ch.ready = can_load;
    assign accept        = char_ch.valid && can_load;

    twt_step u_step (
        .state      (state_reg),
        .char_in    (char_ch.char_in),
        .state_next (state_next),
        .result     (step_result)
    );

    twt_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_result),
        .can_load  (can_load),
        .tok_ch    (tok_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= twt_pkg::MODE_SPACE;
            state_reg.square_depth <= 2'd0;
            state_reg.round_depth  <= 2'd0;
            state_reg.line_count   <= twt_pkg::LINE_ONE;
            state_reg.error_latch  <= twt_pkg::ERR_NONE;
            state_reg.orig_started <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_latch != twt_pkg::ERR_NONE |=>
            state_reg.error_latch == $past(state_reg.error_latch))
        else $error("error latch changed after an error");

    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        tok_ch.valid && tok_ch.error_code != twt_pkg::ERR_NONE |->
            !tok_ch.pair_end && !tok_ch.word_valid && !tok_ch.orig_valid)
        else $error("result flags set while an error is latched");

    a_word_has_orig: assert property (@(posedge clk) disable iff (!rst_n)
        tok_ch.valid && tok_ch.word_valid |-> tok_ch.orig_valid)
        else $error("word letter without original character");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.line_count != 16'd0)
        else $error("line count reached zero");
`endif

endmodule
